/* sv/text_console_writer_core_assert.svh */
// Assertion macros of the text console writer RTL.
// Depends on nothing; the including module supplies clk and arst_n.
`ifndef TEXT_CONSOLE_WRITER_CORE_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TCW_ASSERT_AT(label, clock, reset_n, prop) \
	label: assert property (@(posedge clock) disable iff (!reset_n) prop) \
		else $error("%m: check failed");
`define TCW_ASSERT(label, prop) `TCW_ASSERT_AT(label, clk, arst_n, prop)
`else
`define TCW_ASSERT_AT(label, clock, reset_n, prop)
`define TCW_ASSERT(label, prop)
`endif
`endif

/* sv/tcw_pkg.sv */
// Types and constants of the text console writer.
// Used by tcw_screen_mem, tcw_seq and text_console_writer_core.
`default_nettype none

package tcw_pkg;

	localparam logic [1:0] CMD_PUT   = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
	localparam logic [7:0] BLANK_CHAR   = 8'h20;
	localparam logic [7:0] RESET_ATTR   = 8'h0F;

	localparam logic [3:0] FG_RESET = 4'hF;
	localparam logic [3:0] BG_RESET = 4'h0;

	localparam int IN_WIDTH  = 24;
	localparam int OUT_WIDTH = 32;
	localparam int APB_AW    = 3;

	localparam logic REG_FG = 1'b0;
	localparam logic REG_BG = 1'b1;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_DECODE,
		ST_SCR_RD,
		ST_SCR_WR,
		ST_FILL,
		ST_PUT,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic we;
		logic re;
	} mem_ctl_t;

endpackage

`default_nettype wire

/* sv/tcw_screen_mem.sv */
// Screen store of the text console writer: one write port and one registered read port.
// Depends on tcw_pkg.
`default_nettype none

module tcw_screen_mem #(
	parameter int DEPTH = 2000,
	parameter int AW    = 11
) (
	input  wire logic             clk,
	input  wire tcw_pkg::mem_ctl_t ctl,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [15:0]      wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [15:0]      rdata_q
);

	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[waddr] <= wdata;
		end
		if (ctl.re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* sv/tcw_seq.sv */
// Sequencer, cursor and address unit of the text console writer, with the result register.
// Depends on tcw_pkg and text_console_writer_core_assert.svh; drives tcw_screen_mem.
`default_nettype none
`include "text_console_writer_core_assert.svh"

module tcw_seq #(
	parameter int COLS = 80,
	parameter int ROWS = 25,
	parameter int AW   = 11
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [3:0]                  fg,
	input  wire logic [3:0]                  bg,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [tcw_pkg::IN_WIDTH-1:0] s_tdata,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [tcw_pkg::OUT_WIDTH-1:0]    m_tdata,
	output tcw_pkg::mem_ctl_t                mem_ctl,
	output logic [AW-1:0]                    waddr,
	output logic [15:0]                      wdata,
	output logic [AW-1:0]                    raddr,
	input  wire logic [15:0]                 rdata
);

	localparam int CELLS       = ROWS * COLS;
	localparam int CW          = $clog2(COLS + 1);
	localparam int RW          = $clog2(ROWS);
	localparam int SCROLL_LAST = (ROWS - 1) * COLS - 1;
	localparam int LAST_BASE   = (ROWS - 1) * COLS;

	tcw_pkg::state_t state_q, state_d;

	logic [1:0]    cmd_q;
	logic [7:0]    char_q;
	logic [10:0]   idx_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic [AW-1:0] base_q;
	logic [AW-1:0] ptr_q;
	logic          put_pend_q;
	logic          rd_hit_q;
	logic          m_valid_q;
	logic [7:0]    out_char_q;
	logic [7:0]    out_attr_q;
	logic [4:0]    out_row_q;
	logic [6:0]    out_col_q;

	logic        out_free;
	logic        out_load;
	logic        accept;
	logic        is_nl;
	logic        nl_needed;
	logic        last_row;
	logic        in_range;
	logic [15:0] blank_cell;
	logic [15:0] char_cell;

	assign out_free   = !m_valid_q || m_tready;
	assign accept     = s_tvalid && s_tready;
	assign is_nl      = (char_q == tcw_pkg::NEWLINE_CHAR);
	assign nl_needed  = is_nl || (col_q >= CW'(COLS));
	assign last_row   = (row_q == RW'(ROWS - 1));
	assign in_range   = (32'(idx_q) < 32'(CELLS));
	assign blank_cell = {bg, fg, tcw_pkg::BLANK_CHAR};
	assign char_cell  = {bg, fg, char_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcw_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		mem_ctl  = '0;
		waddr    = ptr_q;
		wdata    = blank_cell;
		raddr    = ptr_q + AW'(COLS);
		s_tready = 1'b0;
		out_load = 1'b0;
		case (state_q)
			tcw_pkg::ST_INIT: begin
				mem_ctl.we = 1'b1;
				wdata      = {tcw_pkg::RESET_ATTR, tcw_pkg::BLANK_CHAR};
				if (ptr_q == AW'(CELLS - 1)) begin
					state_d = tcw_pkg::ST_IDLE;
				end
			end
			tcw_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = tcw_pkg::ST_DECODE;
				end
			end
			tcw_pkg::ST_DECODE: begin
				case (cmd_q)
					tcw_pkg::CMD_PUT: begin
						if (nl_needed) begin
							if (last_row) begin
								state_d = tcw_pkg::ST_SCR_RD;
							end else if (is_nl) begin
								state_d = tcw_pkg::ST_RESP;
							end else begin
								state_d = tcw_pkg::ST_PUT;
							end
						end else begin
							mem_ctl.we = 1'b1;
							waddr      = base_q + AW'(col_q);
							wdata      = char_cell;
							state_d    = tcw_pkg::ST_RESP;
						end
					end
					tcw_pkg::CMD_CLEAR: begin
						state_d = tcw_pkg::ST_FILL;
					end
					tcw_pkg::CMD_READ: begin
						mem_ctl.re = in_range;
						raddr      = AW'(idx_q);
						state_d    = tcw_pkg::ST_RESP;
					end
					default: begin
						state_d = tcw_pkg::ST_RESP;
					end
				endcase
			end
			tcw_pkg::ST_SCR_RD: begin
				mem_ctl.re = 1'b1;
				state_d    = tcw_pkg::ST_SCR_WR;
			end
			tcw_pkg::ST_SCR_WR: begin
				mem_ctl.we = 1'b1;
				wdata      = rdata;
				if (ptr_q == AW'(SCROLL_LAST)) begin
					state_d = tcw_pkg::ST_FILL;
				end else begin
					state_d = tcw_pkg::ST_SCR_RD;
				end
			end
			tcw_pkg::ST_FILL: begin
				mem_ctl.we = 1'b1;
				if (ptr_q == AW'(CELLS - 1)) begin
					state_d = put_pend_q ? tcw_pkg::ST_PUT : tcw_pkg::ST_RESP;
				end
			end
			tcw_pkg::ST_PUT: begin
				mem_ctl.we = 1'b1;
				waddr      = base_q + AW'(col_q);
				wdata      = char_cell;
				state_d    = tcw_pkg::ST_RESP;
			end
			tcw_pkg::ST_RESP: begin
				if (out_free) begin
					out_load = 1'b1;
					s_tready = 1'b1;
					state_d  = s_tvalid ? tcw_pkg::ST_DECODE : tcw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tcw_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q      <= '0;
			col_q      <= '0;
			base_q     <= '0;
			ptr_q      <= '0;
			put_pend_q <= 1'b0;
		end else begin
			case (state_q)
				tcw_pkg::ST_INIT, tcw_pkg::ST_FILL: begin
					ptr_q <= ptr_q + AW'(1);
				end
				tcw_pkg::ST_DECODE: begin
					if (cmd_q == tcw_pkg::CMD_PUT) begin
						if (nl_needed) begin
							col_q      <= '0;
							put_pend_q <= !is_nl;
							ptr_q      <= '0;
							if (!last_row) begin
								row_q  <= row_q + RW'(1);
								base_q <= base_q + AW'(COLS);
							end
						end else begin
							col_q <= col_q + CW'(1);
						end
					end else if (cmd_q == tcw_pkg::CMD_CLEAR) begin
						ptr_q      <= '0;
						put_pend_q <= 1'b0;
					end
				end
				tcw_pkg::ST_SCR_WR: begin
					if (ptr_q == AW'(SCROLL_LAST)) begin
						ptr_q <= AW'(LAST_BASE);
					end else begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
				tcw_pkg::ST_PUT: begin
					col_q <= col_q + CW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= s_tdata[1:0];
			char_q <= s_tdata[9:2];
			idx_q  <= s_tdata[20:10];
		end
		if (state_q == tcw_pkg::ST_DECODE) begin
			rd_hit_q <= in_range;
		end
		if (out_load) begin
			if (cmd_q == tcw_pkg::CMD_READ && rd_hit_q) begin
				out_char_q <= rdata[7:0];
				out_attr_q <= rdata[15:8];
			end else begin
				out_char_q <= '0;
				out_attr_q <= '0;
			end
			out_row_q <= 5'(row_q);
			out_col_q <= 7'(col_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'b0, out_col_q, out_row_q, out_attr_q, out_char_q};

	`TCW_ASSERT(a_col_bound, (32'(col_q) <= COLS))
	`TCW_ASSERT(a_base_tracks_row, (32'(base_q) == 32'(row_q) * COLS))
	`TCW_ASSERT(a_accept_decodes, (accept |=> (state_q == tcw_pkg::ST_DECODE)))

endmodule

`default_nettype wire

/* sv/text_console_writer_core.sv */
// Top level of the text console writer: register port, sequencer and screen store.
// Depends on tcw_pkg, tcw_seq and tcw_screen_mem.
//
//  port group | dir | beat content (low bits first)
//  s_*        | in  | cmd[1:0], char_code[9:2], cell_index[20:10]
//  m_*        | out | cell_char, cell_attr, cursor_row, cursor_col
//  p*         | in  | foreground_color at 0x0, background_color at 0x4
//
// A plain character is written in the decode state, a wrapped one in the put state.
// A scroll reads and writes each cell of rows 1 to ROWS-1 one row up, then blanks the last
// row and writes a wrapped character that follows it; a clear blanks every cell. Both go
// through the single write and read port of the screen store.
// After reset a clearing pass over all ROWS*COLS cells keeps s_tready low.
// A waiting result holds the block until it is taken on the m side.
`default_nettype none

module text_console_writer_core #(
	parameter int SCREEN_COLUMNS = 80,
	parameter int SCREEN_ROWS    = 25
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// cmd[1:0], char_code[9:2], cell_index[20:10], zero fill above
	input  wire logic [tcw_pkg::IN_WIDTH-1:0]  s_tdata,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// cell_char[7:0], cell_attr[15:8], cursor_row[20:16], cursor_col[27:21], zero fill above
	output logic [tcw_pkg::OUT_WIDTH-1:0]      m_tdata,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [tcw_pkg::APB_AW-1:0]    paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);

	localparam int CELLS = SCREEN_ROWS * SCREEN_COLUMNS;
	localparam int AW    = $clog2(CELLS);

	logic [3:0] fg_q;
	logic [3:0] bg_q;

	tcw_pkg::mem_ctl_t mem_ctl;
	logic [AW-1:0]     waddr;
	logic [AW-1:0]     raddr;
	logic [15:0]       wdata;
	logic [15:0]       rdata;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= tcw_pkg::FG_RESET;
			bg_q <= tcw_pkg::BG_RESET;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == tcw_pkg::REG_FG) begin
				fg_q <= pwdata[3:0];
			end else begin
				bg_q <= pwdata[3:0];
			end
		end
	end

	assign prdata = (paddr[2] == tcw_pkg::REG_BG) ? {28'b0, bg_q} : {28'b0, fg_q};

	tcw_seq #(
		.COLS (SCREEN_COLUMNS),
		.ROWS (SCREEN_ROWS),
		.AW   (AW)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.fg       (fg_q),
		.bg       (bg_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.mem_ctl  (mem_ctl),
		.waddr    (waddr),
		.wdata    (wdata),
		.raddr    (raddr),
		.rdata    (rdata)
	);

	tcw_screen_mem #(
		.DEPTH (CELLS),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.ctl     (mem_ctl),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr   (raddr),
		.rdata_q (rdata)
	);

endmodule

`default_nettype wire

/* sim/text_console_writer_core_tb.sv */
// Self-checking testbench for text_console_writer_core: drives command beats and
// color register writes, checks each result beat against a directed row or a screen image of its own.
// Depends on tcw_pkg and the text_console_writer_core RTL.
`timescale 1ns / 100ps

module text_console_writer_core_tb;

	localparam int COLS = 80;
	localparam int ROWS = 25;
	localparam int CELLS = COLS * ROWS;
	localparam int LIMIT_CYCLES = 12_000_000;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [2:0] ADDR_FG = {tcw_pkg::REG_FG, 2'b00};
	localparam logic [2:0] ADDR_BG = {tcw_pkg::REG_BG, 2'b00};
	localparam logic [7:0] SPACE = tcw_pkg::BLANK_CHAR;
	localparam logic [7:0] NL = tcw_pkg::NEWLINE_CHAR;
	localparam logic [7:0] ATTR_RST = tcw_pkg::RESET_ATTR;

	typedef struct packed {
		logic [7:0] cell_char;
		logic [7:0] cell_attr;
		logic [4:0] cursor_row;
		logic [6:0] cursor_col;
	} console_result_t;

	typedef struct packed {
		logic            typed;
		console_result_t want;
	} result_tag_t;

	typedef struct packed {
		logic [1:0]      cmd;
		logic [7:0]      ch;
		logic [10:0]     idx;
		logic            typed;
		console_result_t want;
	} directed_row_t;

	localparam int N_DIRECTED = 17;
	localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
		'{tcw_pkg::CMD_READ,  8'h00, 11'd0,    1'b1, '{SPACE, ATTR_RST, 5'd0, 7'd0}},
		'{tcw_pkg::CMD_READ,  8'h00, 11'd1999, 1'b1, '{SPACE, ATTR_RST, 5'd0, 7'd0}},
		'{tcw_pkg::CMD_READ,  8'h00, 11'd2000, 1'b1, '{8'h00, 8'h00, 5'd0, 7'd0}},
		'{tcw_pkg::CMD_READ,  8'hFF, 11'd2047, 1'b1, '{8'h00, 8'h00, 5'd0, 7'd0}},
		'{CMD_UNUSED,         8'hFF, 11'd2047, 1'b1, '{8'h00, 8'h00, 5'd0, 7'd0}},
		'{tcw_pkg::CMD_PUT,   8'h41, 11'd0,    1'b1, '{8'h00, 8'h00, 5'd0, 7'd1}},
		'{tcw_pkg::CMD_PUT,   8'h00, 11'd0,    1'b1, '{8'h00, 8'h00, 5'd0, 7'd2}},
		'{tcw_pkg::CMD_PUT,   8'hFF, 11'd2047, 1'b1, '{8'h00, 8'h00, 5'd0, 7'd3}},
		'{tcw_pkg::CMD_READ,  8'h00, 11'd0,    1'b1, '{8'h41, ATTR_RST, 5'd0, 7'd3}},
		'{tcw_pkg::CMD_READ,  8'h00, 11'd2,    1'b1, '{8'hFF, ATTR_RST, 5'd0, 7'd3}},
		'{tcw_pkg::CMD_PUT,   NL,    11'd0,    1'b1, '{8'h00, 8'h00, 5'd1, 7'd0}},
		'{tcw_pkg::CMD_PUT,   8'h42, 11'd0,    1'b1, '{8'h00, 8'h00, 5'd1, 7'd1}},
		'{tcw_pkg::CMD_READ,  8'h00, 11'd80,   1'b1, '{8'h42, ATTR_RST, 5'd1, 7'd1}},
		'{tcw_pkg::CMD_CLEAR, 8'hFF, 11'd2047, 1'b1, '{8'h00, 8'h00, 5'd1, 7'd1}},
		'{tcw_pkg::CMD_READ,  8'h00, 11'd80,   1'b1, '{SPACE, ATTR_RST, 5'd1, 7'd1}},
		'{tcw_pkg::CMD_READ,  8'h00, 11'd1,    1'b0, '0},
		'{tcw_pkg::CMD_PUT,   NL,    11'd0,    1'b1, '{8'h00, 8'h00, 5'd2, 7'd0}}
	};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	// cmd[1:0], char_code[9:2], cell_index[20:10], zero fill above
	logic [23:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	// cell_char[7:0], cell_attr[15:8], cursor_row[20:16], cursor_col[27:21], zero fill above
	logic [31:0] m_tdata;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	logic [15:0] screen_img [CELLS] = '{default: {tcw_pkg::RESET_ATTR, tcw_pkg::BLANK_CHAR}};
	logic [4:0]  cur_row = '0;
	logic [6:0]  cur_col = '0;
	logic [3:0]  fg_color = tcw_pkg::FG_RESET;
	logic [3:0]  bg_color = tcw_pkg::BG_RESET;

	console_result_t expected_results [$];
	result_tag_t     pending_tags [$];

	int          tx_idle_pct;
	int          rx_idle_pct;
	logic        rx_hold;
	int          sent_count = 0;
	int          checked_count = 0;
	int          random_items = 0;
	int          mismatch_count = 0;
	int          n_reads = 0;
	int          n_clears = 0;
	int          n_scrolls = 0;
	int          n_wraps = 0;
	int unsigned cycle_count = 0;

	text_console_writer_core #(
		.SCREEN_COLUMNS(COLS),
		.SCREEN_ROWS(ROWS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatch_count++;
		if (mismatch_count <= 20)
			$display("MISMATCH %s: got 0x%0h, want 0x%0h (result %0d, cycle %0d)",
				what, got, want, checked_count, cycle_count);
	endtask

	function automatic logic [15:0] colored_cell(input logic [7:0] ch);
		return {bg_color, fg_color, ch};
	endfunction

	task automatic blank_screen_row(input int r);
		for (int c = 0; c < COLS; c++)
			screen_img[r * COLS + c] = colored_cell(tcw_pkg::BLANK_CHAR);
	endtask

	task automatic advance_line();
		cur_col = '0;
		if (cur_row < ROWS - 1) begin
			cur_row++;
		end else begin
			for (int i = 0; i < (ROWS - 1) * COLS; i++)
				screen_img[i] = screen_img[i + COLS];
			blank_screen_row(ROWS - 1);
			n_scrolls++;
		end
	endtask

	task automatic console_step(input logic [1:0] cmd, input logic [7:0] ch,
			input logic [10:0] idx, output console_result_t res);
		res = '0;
		case (cmd)
			tcw_pkg::CMD_PUT: begin
				if (ch == tcw_pkg::NEWLINE_CHAR) begin
					advance_line();
				end else begin
					if (cur_col >= COLS) begin
						advance_line();
						n_wraps++;
					end
					screen_img[cur_row * COLS + cur_col] = colored_cell(ch);
					cur_col++;
				end
			end
			tcw_pkg::CMD_CLEAR: begin
				for (int r = 0; r < ROWS; r++)
					blank_screen_row(r);
				n_clears++;
			end
			tcw_pkg::CMD_READ: begin
				n_reads++;
				if (idx < CELLS) begin
					res.cell_char = screen_img[idx][7:0];
					res.cell_attr = screen_img[idx][15:8];
				end
			end
			default: ;
		endcase
		res.cursor_row = cur_row;
		res.cursor_col = cur_col;
	endtask

	always @(posedge clk) begin : beat_monitor
		console_result_t predicted;
		console_result_t want;
		console_result_t got;
		result_tag_t     tag;
		if (arst_n && s_tvalid && s_tready) begin
			console_step(s_tdata[1:0], s_tdata[9:2], s_tdata[20:10], predicted);
			tag = pending_tags.pop_front();
			expected_results.push_back(tag.typed ? tag.want : predicted);
		end
		if (arst_n && m_tvalid && m_tready) begin
			got.cell_char = m_tdata[7:0];
			got.cell_attr = m_tdata[15:8];
			got.cursor_row = m_tdata[20:16];
			got.cursor_col = m_tdata[27:21];
			if (expected_results.size() == 0) begin
				report_mismatch("result beat with nothing pending", int'(m_tdata), 0);
			end else begin
				want = expected_results.pop_front();
				if (got.cell_char != want.cell_char)
					report_mismatch("cell_char", int'(got.cell_char), int'(want.cell_char));
				if (got.cell_attr != want.cell_attr)
					report_mismatch("cell_attr", int'(got.cell_attr), int'(want.cell_attr));
				if (got.cursor_row != want.cursor_row)
					report_mismatch("cursor_row", int'(got.cursor_row),
						int'(want.cursor_row));
				if (got.cursor_col != want.cursor_col)
					report_mismatch("cursor_col", int'(got.cursor_col),
						int'(want.cursor_col));
			end
			checked_count++;
		end
	end

	always @(posedge clk)
		m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);

	// Long receiver stall early in the run so the block backs up and stalls its input.
	initial begin
		rx_hold = 1'b0;
		wait (sent_count >= 60);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (400) @(posedge clk);
		rx_hold <= 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles with %0d results pending.",
				cycle_count, sent_count - checked_count);
			$display("[text_console_writer_core] ERROR");
			$finish;
		end
	end

	task automatic send_item(input logic [1:0] cmd, input logic [7:0] ch,
			input logic [10:0] idx, input logic typed, input console_result_t want);
		result_tag_t tag;
		int gap;
		gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 4) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tag.typed = typed;
		tag.want = want;
		pending_tags.push_back(tag);
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, idx, ch, cmd};
		do @(posedge clk); while (!s_tready);
		sent_count++;
	endtask

	task automatic emit(input logic [1:0] cmd, input logic [7:0] ch, input logic [10:0] idx);
		send_item(cmd, ch, idx, 1'b0, '0);
		if (cmd != CMD_UNUSED)
			random_items++;
	endtask

	task automatic emit_text_char();
		logic [7:0] ch;
		ch = 8'($urandom_range(0, 255));
		if (ch == tcw_pkg::NEWLINE_CHAR)
			ch = tcw_pkg::BLANK_CHAR;
		emit(tcw_pkg::CMD_PUT, ch, 11'($urandom_range(0, 2047)));
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (checked_count < sent_count)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_color_reg(input logic [2:0] addr, input logic [3:0] value);
		logic [27:0] junk;
		junk = 28'($urandom());
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= {junk, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata != {28'd0, value})
			report_mismatch("register readback", int'(prdata), int'(value));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_colors(input logic [3:0] fg, input logic [3:0] bg);
		set_color_reg(ADDR_FG, fg);
		fg_color = fg;
		set_color_reg(ADDR_BG, bg);
		bg_color = bg;
	endtask

	// Mostly short text lines and newlines so the cursor reaches the bottom and
	// scrolls; some overlong lines for wraps, reads mostly near the cursor, unused commands, rare clears.
	task automatic run_random(input int quota);
		int target;
		int kind;
		int n;
		int r;
		target = random_items + quota;
		while (random_items < target) begin
			kind = $urandom_range(99);
			if (kind < 55) begin
				n = $urandom_range(0, 12);
				repeat (n) emit_text_char();
				if ($urandom_range(99) < 85)
					emit(tcw_pkg::CMD_PUT, tcw_pkg::NEWLINE_CHAR,
						11'($urandom_range(0, 2047)));
			end else if (kind < 63) begin
				n = $urandom_range(76, 96);
				repeat (n) emit_text_char();
				if ($urandom_range(1) == 1)
					emit(tcw_pkg::CMD_PUT, tcw_pkg::NEWLINE_CHAR,
						11'($urandom_range(0, 2047)));
			end else if (kind < 80) begin
				repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(3) == 0) begin
						emit(tcw_pkg::CMD_READ, 8'($urandom_range(0, 255)),
							11'($urandom_range(0, 2047)));
					end else begin
						r = int'(cur_row) - $urandom_range(0, 2);
						if (r < 0)
							r = 0;
						emit(tcw_pkg::CMD_READ, 8'($urandom_range(0, 255)),
							11'(r * COLS + int'($urandom_range(0, COLS - 1))));
					end
				end
			end else if (kind < 85) begin
				if ($urandom_range(1) == 1)
					emit(CMD_UNUSED, 8'($urandom_range(0, 255)),
						11'($urandom_range(0, 2047)));
				else
					emit(tcw_pkg::CMD_PUT, 8'($urandom_range(0, 255)),
						11'($urandom_range(0, 2047)));
			end else if (kind < 87) begin
				emit(tcw_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)),
					11'($urandom_range(0, 2047)));
			end else begin
				repeat ($urandom_range(1, 8))
					emit(tcw_pkg::CMD_PUT, tcw_pkg::NEWLINE_CHAR,
						11'($urandom_range(0, 2047)));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		tx_idle_pct = 32;
		rx_idle_pct = 47;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < N_DIRECTED; i++)
			send_item(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].ch, DIRECTED_ROWS[i].idx,
				DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
		drain_results();

		set_colors(4'h0, 4'hF);
		run_random(250);
		drain_results();

		tx_idle_pct = 47;
		rx_idle_pct = 32;
		set_colors(4'hF, 4'h0);
		run_random(250);
		drain_results();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_colors(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
		run_random(250);
		drain_results();

		$display("Checked %0d result beats: %0d reads, %0d clears, %0d scrolls, %0d wraps,",
			checked_count, n_reads, n_clears, n_scrolls, n_wraps);
		$display("under four color settings in %0d cycles.", cycle_count);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("[text_console_writer_core] OK");
		else
			$display("[text_console_writer_core] ERROR");
		$finish;
	end

endmodule

/* sim.f */
+incdir+sv
sv/tcw_pkg.sv
sv/tcw_screen_mem.sv
sv/tcw_seq.sv
sv/text_console_writer_core.sv
sim/text_console_writer_core_tb.sv
